/* hdl/tlc_pkg.sv */
// tlc_pkg: shared constants, types and helpers for the two-level tag lookup
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

    // item and configuration field widths
    localparam int ADDR_W     = 64;
    localparam int WAY_W      = 3;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 3;

    // address split limits
    localparam logic [3:0] OFFSET_CAP   = 4'd12;
    localparam int         L2_INDEX_CAP = 10;
    localparam int         L3_INDEX_CAP = 12;

    // default store geometry
    localparam int DEF_L2_MAX_SETS = 1024;
    localparam int DEF_L3_MAX_SETS = 4096;
    localparam int DEF_MAX_WAYS    = 8;

    // replacement generator seed
    localparam logic [15:0] LFSR_RESET = 16'hACE1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_L2_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_INDEX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_WAYS   = 3'd5;

    // write control for one tag store
    typedef struct packed {
        logic             en;
        logic             clear;
        logic [WAY_W-1:0] way;
    } tlc_wr_t;

    // saturate a 4-bit field at an upper bound
    function automatic logic [3:0] cap4(input logic [3:0] v, input logic [3:0] hi);
        return (v > hi) ? hi : v;
    endfunction

endpackage

`default_nettype wire

/* hdl/tlc_if.sv */
// tlc_req_if / tlc_rsp_if: valid-ready channels of the two-level tag lookup
// depends on tlc_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface tlc_req_if;
    logic                       valid;
    logic                       ready;
    logic [tlc_pkg::ADDR_W-1:0] miss_address;

    modport source (output valid, output miss_address, input ready);
    modport sink (input valid, input miss_address, output ready);
endinterface

interface tlc_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      l2_hit;
    logic                      l3_hit;
    logic                      filled;
    logic [tlc_pkg::WAY_W-1:0] fill_way;

    modport source (output valid, output l2_hit, output l3_hit, output filled,
                    output fill_way, input ready);
    modport sink (input valid, input l2_hit, input l3_hit, input filled,
                  input fill_way, output ready);
endinterface

`default_nettype wire

/* hdl/two_level_cache_tag_lookup.sv */
// two_level_cache_tag_lookup: top level with control, config and replacement
// depends on tlc_pkg, tlc_if, tlc_split and tlc_tag_store
//
// Takes one miss address per item on req and returns one item on rsp with
// l2_hit, l3_hit, filled and fill_way. Six configuration registers set the
// offset, index and way counts of each level; they are to be written through
// cfg_we / cfg_index / cfg_data only while no item is in flight, a rule for the
// user that the block itself does not enforce. An accepted item reads both tag
// stores in the same edge; in ST_LOOK it compares the ways in use and, once
// the output register is free, writes back both stores on a double miss and
// loads the result register. An item takes one synchronous read and, on a
// double miss, one write-back per store. req.ready is high only between
// items, so a new item waits for the write of the previous one.
// After reset the block sweeps both stores to zero, one set a cycle, over
// max(L2_MAX_SETS, L3_MAX_SETS) sets (4096 by default) with req.ready low.
// When rsp is stalled, one result waits in the output register and the next
// item is still accepted; that item holds in its compare cycle until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module two_level_cache_tag_lookup #(
    parameter int L2_MAX_SETS = tlc_pkg::DEF_L2_MAX_SETS,
    parameter int L3_MAX_SETS = tlc_pkg::DEF_L3_MAX_SETS,
    parameter int MAX_WAYS    = tlc_pkg::DEF_MAX_WAYS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tlc_req_if.sink                                req,
    tlc_rsp_if.source                              rsp,
    input  wire logic                              cfg_we,
    input  wire logic [tlc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tlc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int L2_SET_W = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
    localparam int L3_SET_W = (L3_MAX_SETS > 1) ? $clog2(L3_MAX_SETS) : 1;
    localparam int CLR_N    = (L2_MAX_SETS > L3_MAX_SETS) ? L2_MAX_SETS : L3_MAX_SETS;
    localparam int CLR_W    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [CLR_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [15:0]                  lfsr_reg, lfsr_next;

    logic [3:0]                   l2_offset_reg, l2_index_reg;
    logic [1:0]                   l2_ways_reg;
    logic [3:0]                   l3_offset_reg, l3_index_reg;
    logic [1:0]                   l3_ways_reg;

    logic [L2_SET_W-1:0]          s2_reg, s2_live;
    logic [L3_SET_W-1:0]          s3_reg, s3_live;
    logic [tlc_pkg::ADDR_W-1:0]   t2_reg, t2_live;
    logic [tlc_pkg::ADDR_W-1:0]   t3_reg, t3_live;

    logic                         out_valid_reg;
    logic                         out_l2_hit_reg, out_l3_hit_reg, out_filled_reg;
    logic [tlc_pkg::WAY_W-1:0]    out_way_reg;

    logic                         accept;
    logic                         clearing;
    logic                         finish;
    logic                         l2_hit, l3_hit;
    logic                         double_miss;
    logic                         fill_fire;
    logic [1:0]                   min_log;
    logic [3:0]                   lanes;
    logic [3:0]                   fill_n;
    logic [tlc_pkg::WAY_W-1:0]    fill_mask;
    logic [tlc_pkg::WAY_W-1:0]    fill_way;
    logic                         l2_clr_en;
    tlc_pkg::tlc_wr_t             l2_wr, l3_wr;
    logic [L2_SET_W-1:0]          l2_wr_set;
    logic [L3_SET_W-1:0]          l3_wr_set;

    // handshake
    assign clearing  = (state_reg == ST_CLEAR);
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign finish    = (state_reg == ST_LOOK) && (!out_valid_reg || rsp.ready);

    // address split for both levels
    tlc_split #(
        .MAX_SETS  (L2_MAX_SETS),
        .INDEX_CAP (tlc_pkg::L2_INDEX_CAP),
        .SET_W     (L2_SET_W)
    ) u_split_l2 (
        .addr        (req.miss_address),
        .offset_bits (l2_offset_reg),
        .index_bits  (l2_index_reg),
        .set         (s2_live),
        .tag         (t2_live)
    );

    tlc_split #(
        .MAX_SETS  (L3_MAX_SETS),
        .INDEX_CAP (tlc_pkg::L3_INDEX_CAP),
        .SET_W     (L3_SET_W)
    ) u_split_l3 (
        .addr        (req.miss_address),
        .offset_bits (l3_offset_reg),
        .index_bits  (l3_index_reg),
        .set         (s3_live),
        .tag         (t3_live)
    );

    // replacement way: next generator value masked by the smaller way count
    assign min_log     = (l2_ways_reg < l3_ways_reg) ? l2_ways_reg : l3_ways_reg;
    assign lanes       = 4'd1 << min_log;
    assign fill_n      = (lanes > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : lanes;
    assign fill_mask   = 3'(fill_n - 4'd1);
    assign lfsr_next   = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                          lfsr_reg[15:1]};
    assign fill_way    = lfsr_next[tlc_pkg::WAY_W-1:0] & fill_mask;

    assign double_miss = !l2_hit && !l3_hit;
    assign fill_fire   = finish && double_miss;

    // store write control: clearing sweep or fill
    assign l2_clr_en = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(L2_MAX_SETS));
    assign l2_wr     = '{en: clearing ? l2_clr_en : fill_fire, clear: clearing, way: fill_way};
    assign l3_wr     = '{en: clearing || fill_fire, clear: clearing, way: fill_way};
    assign l2_wr_set = clearing ? clr_cnt_reg[L2_SET_W-1:0] : s2_reg;
    assign l3_wr_set = clearing ? clr_cnt_reg[L3_SET_W-1:0] : s3_reg;

    tlc_tag_store #(
        .SETS  (L2_MAX_SETS),
        .WAYS  (MAX_WAYS),
        .SET_W (L2_SET_W)
    ) u_store_l2 (
        .clk      (clk),
        .rd_en    (accept),
        .rd_set   (s2_live),
        .wr       (l2_wr),
        .wr_set   (l2_wr_set),
        .tag      (t2_reg),
        .ways_log (l2_ways_reg),
        .hit      (l2_hit)
    );

    tlc_tag_store #(
        .SETS  (L3_MAX_SETS),
        .WAYS  (MAX_WAYS),
        .SET_W (L3_SET_W)
    ) u_store_l3 (
        .clk      (clk),
        .rd_en    (accept),
        .rd_set   (s3_live),
        .wr       (l3_wr),
        .wr_set   (l3_wr_set),
        .tag      (t3_reg),
        .ways_log (l3_ways_reg),
        .hit      (l3_hit)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            lfsr_reg    <= tlc_pkg::LFSR_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (fill_fire)
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l2_offset_reg <= 4'd6;
            l2_index_reg  <= 4'd10;
            l2_ways_reg   <= 2'd3;
            l3_offset_reg <= 4'd6;
            l3_index_reg  <= 4'd12;
            l3_ways_reg   <= 2'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlc_pkg::CFG_L2_OFFSET: l2_offset_reg <= cfg_data;
                tlc_pkg::CFG_L2_INDEX:  l2_index_reg  <= cfg_data;
                tlc_pkg::CFG_L2_WAYS:   l2_ways_reg   <= cfg_data[1:0];
                tlc_pkg::CFG_L3_OFFSET: l3_offset_reg <= cfg_data;
                tlc_pkg::CFG_L3_INDEX:  l3_index_reg  <= cfg_data;
                tlc_pkg::CFG_L3_WAYS:   l3_ways_reg   <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // item address fields held for compare and write-back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_reg <= s2_live;
            s3_reg <= s3_live;
            t2_reg <= t2_live;
            t3_reg <= t3_live;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_l2_hit_reg <= l2_hit;
            out_l3_hit_reg <= !l2_hit && l3_hit;
            out_filled_reg <= double_miss;
            out_way_reg    <= double_miss ? fill_way : '0;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.l2_hit   = out_l2_hit_reg;
    assign rsp.l3_hit   = out_l3_hit_reg;
    assign rsp.filled   = out_filled_reg;
    assign rsp.fill_way = out_way_reg;

endmodule

`default_nettype wire

/* hdl/tlc_split.sv */
// tlc_split: splits a byte address into set number and tag for one level
// depends on tlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlc_split #(
    parameter int MAX_SETS  = tlc_pkg::DEF_L2_MAX_SETS,
    parameter int INDEX_CAP = tlc_pkg::L2_INDEX_CAP,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  wire logic [tlc_pkg::ADDR_W-1:0] addr,
    input  wire logic [3:0]                 offset_bits,
    input  wire logic [3:0]                 index_bits,
    output logic      [SET_W-1:0]           set,
    output logic      [tlc_pkg::ADDR_W-1:0] tag
);

    localparam int  RAW_W = INDEX_CAP;
    localparam bit  POW2  = ((MAX_SETS & (MAX_SETS - 1)) == 0);

    logic [3:0]                 off_c;
    logic [3:0]                 idx_c;
    logic [tlc_pkg::ADDR_W-1:0] shifted;
    logic [RAW_W-1:0]           raw;
    logic [4:0]                 tag_shift;

    // limit the configured field sizes
    assign off_c = tlc_pkg::cap4(offset_bits, tlc_pkg::OFFSET_CAP);
    assign idx_c = tlc_pkg::cap4(index_bits, 4'(INDEX_CAP));

    // index field, masked to the configured number of bits
    assign shifted = addr >> off_c;
    always_comb
    begin
        for (int i = 0; i < RAW_W; i++)
        begin
            raw[i] = shifted[i] & (5'(i) < {1'b0, idx_c});
        end
    end

    // tag is everything above offset and index
    assign tag_shift = {1'b0, off_c} + {1'b0, idx_c};
    assign tag       = addr >> tag_shift;

    // wrap the index onto the store depth
    generate
        if (POW2)
        begin : g_mask
            logic [RAW_W+SET_W-1:0] raw_ext;
            assign raw_ext = {{SET_W{1'b0}}, raw};
            assign set     = (MAX_SETS == 1) ? '0 : raw_ext[SET_W-1:0];
        end
        else
        begin : g_wrap
            // remainder by the constant depth: quotient from a reciprocal
            // multiply, exact for every index value, then one subtract
            localparam int     LOG_M  = $clog2(MAX_SETS);
            localparam int     SHIFT  = RAW_W + LOG_M;
            localparam int     PROD_W = 2 * RAW_W + 2;
            localparam longint RECIP  =
                ((longint'(1) << SHIFT) + longint'(MAX_SETS) - longint'(1))
                / longint'(MAX_SETS);

            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] quot;
            logic [PROD_W-1:0] back;

            assign prod = PROD_W'(raw) * PROD_W'(RECIP);
            assign quot = prod >> SHIFT;
            assign back = quot * PROD_W'(MAX_SETS);
            assign set  = SET_W'(PROD_W'(raw) - back);
        end
    endgenerate

endmodule

`default_nettype wire

/* hdl/tlc_tag_store.sv */
// tlc_tag_store: one set-associative tag store, a row of all ways per set,
// with registered read, way compare and read-modify-write fill; uses tlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlc_tag_store #(
    parameter int SETS  = tlc_pkg::DEF_L2_MAX_SETS,
    parameter int WAYS  = tlc_pkg::DEF_MAX_WAYS,
    parameter int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [SET_W-1:0]           rd_set,
    input  wire tlc_pkg::tlc_wr_t           wr,
    input  wire logic [SET_W-1:0]           wr_set,
    input  wire logic [tlc_pkg::ADDR_W-1:0] tag,
    input  wire logic [1:0]                 ways_log,
    output logic                            hit
);

    localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0][tlc_pkg::ADDR_W-1:0] mem [SETS];
    logic [WAYS-1:0][tlc_pkg::ADDR_W-1:0] row_reg;
    logic [WAYS-1:0][tlc_pkg::ADDR_W-1:0] wr_row;
    logic [WAY_IDX_W-1:0]                 way_idx;
    logic [3:0]                           lanes;

    assign way_idx = wr.way[WAY_IDX_W-1:0];
    assign lanes   = 4'd1 << ways_log;

    // row write and registered row read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_set] <= wr_row;
        end
        if (rd_en)
        begin
            row_reg <= mem[rd_set];
        end
    end

    // row to write back: cleared, or the read row with one way replaced
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (wr.clear)
            begin
                wr_row[w] = '0;
            end
            else if (WAY_IDX_W'(w) == way_idx)
            begin
                wr_row[w] = tag;
            end
            else
            begin
                wr_row[w] = row_reg[w];
            end
        end
    end

    // compare the tag against the ways in use
    always_comb
    begin
        hit = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if ((row_reg[w] == tag) && (4'(w) < lanes))
            begin
                hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* sim/two_level_cache_tag_lookup_tb.sv */
// two_level_cache_tag_lookup_tb: self-checking bench for the two-level tag lookup
// depends on tlc_pkg, tlc_if and the two_level_cache_tag_lookup top level
// a directed table then random config phases, every item checked against a tag-store predictor or its typed row
`timescale 1ns / 1ps

module two_level_cache_tag_lookup_tb;

    // package constants used by the bench
    localparam int          ADDR_W       = tlc_pkg::ADDR_W;
    localparam int          WAY_W        = tlc_pkg::WAY_W;
    localparam int          CFG_IDX_W    = tlc_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W   = tlc_pkg::CFG_DATA_W;
    localparam logic [3:0]  OFFSET_CAP   = tlc_pkg::OFFSET_CAP;
    localparam int          L2_INDEX_CAP = tlc_pkg::L2_INDEX_CAP;
    localparam int          L3_INDEX_CAP = tlc_pkg::L3_INDEX_CAP;
    localparam logic [15:0] LFSR_RESET   = tlc_pkg::LFSR_RESET;

    localparam logic [CFG_IDX_W-1:0] CFG_L2_OFFSET = tlc_pkg::CFG_L2_OFFSET;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_INDEX  = tlc_pkg::CFG_L2_INDEX;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WAYS   = tlc_pkg::CFG_L2_WAYS;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_OFFSET = tlc_pkg::CFG_L3_OFFSET;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_INDEX  = tlc_pkg::CFG_L3_INDEX;
    localparam logic [CFG_IDX_W-1:0] CFG_L3_WAYS   = tlc_pkg::CFG_L3_WAYS;

    localparam int L2_SETS = tlc_pkg::DEF_L2_MAX_SETS;
    localparam int L3_SETS = tlc_pkg::DEF_L3_MAX_SETS;
    localparam int WAYS    = tlc_pkg::DEF_MAX_WAYS;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // register values after reset
    localparam logic [CFG_DATA_W-1:0] RST_L2_OFFSET = 4'd6;
    localparam logic [CFG_DATA_W-1:0] RST_L2_INDEX  = 4'd10;
    localparam logic [CFG_DATA_W-1:0] RST_L2_WAYS   = 4'd3;
    localparam logic [CFG_DATA_W-1:0] RST_L3_OFFSET = 4'd6;
    localparam logic [CFG_DATA_W-1:0] RST_L3_INDEX  = 4'd12;
    localparam logic [CFG_DATA_W-1:0] RST_L3_WAYS   = 4'd3;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int POOL_DEPTH      = 32;
    localparam int MAX_PRINTS      = 64;

    typedef struct packed {
        logic             l2_hit;
        logic             l3_hit;
        logic             filled;
        logic [WAY_W-1:0] fill_way;
    } lookup_result_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [ADDR_W-1:0]     addr;
        bit                    typed;
        lookup_result_t        want;
    } stim_row_t;

    localparam lookup_result_t L2_HIT_RESULT =
        '{l2_hit: 1'b1, l3_hit: 1'b0, filled: 1'b0, fill_way: '0};
    localparam lookup_result_t FILL_WAY0_RESULT =
        '{l2_hit: 1'b0, l3_hit: 1'b0, filled: 1'b1, fill_way: '0};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tlc_req_if req_ch ();
    tlc_rsp_if rsp_ch ();

    two_level_cache_tag_lookup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: both tag stores, replacement lfsr, register copies
    logic [ADDR_W-1:0]     l2_tags [L2_SETS][WAYS];
    logic [ADDR_W-1:0]     l3_tags [L3_SETS][WAYS];
    logic [15:0]           victim_lfsr;
    logic [CFG_DATA_W-1:0] l2_off_q, l2_idx_q, l3_off_q, l3_idx_q;
    logic [1:0]            l2_ways_q, l3_ways_q;

    lookup_result_t    pending_results [$];
    logic [ADDR_W-1:0] recent_addrs [$];
    stim_row_t         directed_rows [$];
    int                mismatch_count;
    int                results_seen;
    bit                long_hold_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic clear_tag_model();
        for (int s = 0; s < L2_SETS; s++)
            for (int w = 0; w < WAYS; w++)
                l2_tags[s][w] = '0;
        for (int s = 0; s < L3_SETS; s++)
            for (int w = 0; w < WAYS; w++)
                l3_tags[s][w] = '0;
        victim_lfsr = LFSR_RESET;
        l2_off_q    = RST_L2_OFFSET;
        l2_idx_q    = RST_L2_INDEX;
        l2_ways_q   = RST_L2_WAYS[1:0];
        l3_off_q    = RST_L3_OFFSET;
        l3_idx_q    = RST_L3_INDEX;
        l3_ways_q   = RST_L3_WAYS[1:0];
    endtask

    // one lookup: search l2, then l3, fill both on a double miss
    function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
        logic [3:0]        off2, idx2, off3, idx3;
        logic [ADDR_W-1:0] t2, t3;
        int                s2, s3, n2, n3, nmin;
        logic              fb;
        logic [WAY_W-1:0]  way;
        lookup_result_t    r;
        off2 = (l2_off_q > OFFSET_CAP) ? OFFSET_CAP : l2_off_q;
        idx2 = (l2_idx_q > 4'(L2_INDEX_CAP)) ? 4'(L2_INDEX_CAP) : l2_idx_q;
        off3 = (l3_off_q > OFFSET_CAP) ? OFFSET_CAP : l3_off_q;
        idx3 = (l3_idx_q > 4'(L3_INDEX_CAP)) ? 4'(L3_INDEX_CAP) : l3_idx_q;
        s2 = int'(((addr >> off2) & ((64'd1 << idx2) - 64'd1)) % L2_SETS);
        s3 = int'(((addr >> off3) & ((64'd1 << idx3) - 64'd1)) % L3_SETS);
        t2 = addr >> (int'(off2) + int'(idx2));
        t3 = addr >> (int'(off3) + int'(idx3));
        n2 = 1 << l2_ways_q;
        n3 = 1 << l3_ways_q;
        if (n2 > WAYS)
            n2 = WAYS;
        if (n3 > WAYS)
            n3 = WAYS;
        r = '0;
        for (int w = 0; w < n2; w++)
            if (l2_tags[s2][w] == t2)
                r.l2_hit = 1'b1;
        if (!r.l2_hit)
        begin
            for (int w = 0; w < n3; w++)
                if (l3_tags[s3][w] == t3)
                    r.l3_hit = 1'b1;
            if (!r.l3_hit)
            begin
                nmin = (n2 < n3) ? n2 : n3;
                fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
                victim_lfsr = {fb, victim_lfsr[15:1]};
                way = victim_lfsr[WAY_W-1:0] & WAY_W'(nmin - 1);
                l2_tags[s2][way] = t2;
                l3_tags[s3][way] = t3;
                r.filled   = 1'b1;
                r.fill_way = way;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("result %0d at %0t: %s got %0h want %0h",
                     results_seen, $realtime, field, got, want);
        mismatch_count++;
    endtask

    // register write with a one-cycle cfg_we strobe, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_L2_OFFSET: l2_off_q  = data;
            CFG_L2_INDEX:  l2_idx_q  = data;
            CFG_L2_WAYS:   l2_ways_q = data[1:0];
            CFG_L3_OFFSET: l3_off_q  = data;
            CFG_L3_INDEX:  l3_idx_q  = data;
            CFG_L3_WAYS:   l3_ways_q = data[1:0];
            default: ;
        endcase
    endtask

    // offer one address and hold it until accepted
    task automatic send_addr(input logic [ADDR_W-1:0] addr, input bit typed,
                             input lookup_result_t typed_want);
        lookup_result_t predicted;
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.miss_address <= addr;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predicted = predict_lookup(addr);
        pending_results.insert(pending_results.size(), typed ? typed_want : predicted);
    endtask

    // stop offering and wait until every lookup has come back
    task automatic drain_lookups();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // directed table rows
    function automatic void add_item_row(input logic [ADDR_W-1:0] addr);
        stim_row_t row;
        row = '{is_cfg: 1'b0, reg_idx: '0, reg_data: '0, addr: addr, typed: 1'b0, want: '0};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_checked_row(input logic [ADDR_W-1:0] addr,
                                            input lookup_result_t want);
        stim_row_t row;
        row = '{is_cfg: 1'b0, reg_idx: '0, reg_data: '0, addr: addr, typed: 1'b1, want: want};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{is_cfg: 1'b1, reg_idx: idx, reg_data: data, addr: '0, typed: 1'b0, want: '0};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void build_directed_rows();
        // cleared stores: tag zero hits, all-ones misses then hits
        add_checked_row(64'h0, L2_HIT_RESULT);
        add_item_row(64'hFFFF_FFFF_FFFF_FFFF);
        add_checked_row(64'hFFFF_FFFF_FFFF_FFFF, L2_HIT_RESULT);
        add_checked_row(64'h0000_0000_0000_003F, L2_HIT_RESULT);
        add_item_row(64'h8000_0000_0000_0000);
        add_item_row(64'h0000_0000_0100_0000);
        // one way per level: only way zero searched and filled
        add_cfg_row(CFG_L2_WAYS, 4'd0);
        add_cfg_row(CFG_L3_WAYS, 4'd0);
        add_item_row(64'hFFFF_FFFF_FFFF_FFFF);
        add_checked_row(64'h1234_5678_9ABC_DEF0, FILL_WAY0_RESULT);
        // offsets and indexes above their caps, way fields with upper bits set
        add_cfg_row(CFG_L2_OFFSET, 4'hF);
        add_cfg_row(CFG_L2_INDEX, 4'hF);
        add_cfg_row(CFG_L3_OFFSET, 4'd13);
        add_cfg_row(CFG_L3_INDEX, 4'hF);
        add_cfg_row(CFG_L2_WAYS, 4'hF);
        add_cfg_row(CFG_L3_WAYS, 4'hF);
        add_item_row(64'hFFFF_FFFF_FFFF_FFFF);
        add_item_row(64'h0000_0000_003F_FFFF);
        add_item_row(64'h00FF_FFFF_FFFF_FFFF);
        // single set, single way: tag is the whole address
        add_cfg_row(CFG_L2_OFFSET, 4'd0);
        add_cfg_row(CFG_L2_INDEX, 4'd0);
        add_cfg_row(CFG_L2_WAYS, 4'd0);
        add_cfg_row(CFG_L3_OFFSET, 4'd0);
        add_cfg_row(CFG_L3_INDEX, 4'd0);
        add_cfg_row(CFG_L3_WAYS, 4'd0);
        add_item_row(64'h0);
        add_item_row(64'h1);
        add_item_row(64'h2);
        add_item_row(64'h1);
        // writes to unused indexes change nothing
        add_cfg_row(CFG_SPARE_6, 4'hF);
        add_cfg_row(CFG_SPARE_7, 4'hA);
        add_item_row(64'h2);
    endfunction

    // random address, mostly near recent ones so that hits come often
    function automatic logic [ADDR_W-1:0] next_addr();
        logic [ADDR_W-1:0] a, base, full;
        int                pick;
        pick = $urandom_range(0, 99);
        full = {$urandom, $urandom};
        base = (recent_addrs.size() != 0) ?
               recent_addrs[$urandom_range(0, recent_addrs.size() - 1)] : full;
        if (pick < 35)
            a = base;
        else if (pick < 50)
            a = {base[ADDR_W-1:12], full[11:0]};
        else if (pick < 65)
            a = base ^ (64'd1 << $urandom_range(0, 23));
        else if (pick < 80)
            a = {40'd0, full[23:0]} >> $urandom_range(0, 23);
        else
            a = full;
        recent_addrs.insert(recent_addrs.size(), a);
        if (recent_addrs.size() > POOL_DEPTH)
            void'(recent_addrs.pop_front());
        return a;
    endfunction

    // extreme, above-cap or in-range register value
    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int hi);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return CFG_DATA_W'(hi);
            2: return CFG_DATA_W'($urandom_range(hi + 1, 15));
            default: return CFG_DATA_W'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic configure_phase(input int phase);
        logic [CFG_DATA_W-1:0] v_l2_off, v_l2_idx, v_l2_ways, v_l3_off, v_l3_idx, v_l3_ways;
        if (phase == 0)
        begin
            v_l2_off = 4'hF; v_l2_idx = 4'hF; v_l2_ways = 4'hF;
            v_l3_off = 4'hF; v_l3_idx = 4'hF; v_l3_ways = 4'hF;
        end
        else if (phase == 1)
        begin
            v_l2_off = '0; v_l2_idx = '0; v_l2_ways = '0;
            v_l3_off = '0; v_l3_idx = '0; v_l3_ways = '0;
        end
        else if (phase == 2)
        begin
            v_l2_off = RST_L2_OFFSET; v_l2_idx = RST_L2_INDEX; v_l2_ways = RST_L2_WAYS;
            v_l3_off = RST_L3_OFFSET; v_l3_idx = RST_L3_INDEX; v_l3_ways = RST_L3_WAYS;
        end
        else
        begin
            v_l2_off  = pick_reg_value(int'(OFFSET_CAP));
            v_l2_idx  = pick_reg_value(L2_INDEX_CAP);
            v_l2_ways = pick_reg_value(3);
            v_l3_off  = pick_reg_value(int'(OFFSET_CAP));
            v_l3_idx  = pick_reg_value(L3_INDEX_CAP);
            v_l3_ways = pick_reg_value(3);
        end
        write_reg(CFG_L2_OFFSET, v_l2_off);
        write_reg(CFG_L2_INDEX, v_l2_idx);
        write_reg(CFG_L2_WAYS, v_l2_ways);
        write_reg(CFG_L3_OFFSET, v_l3_off);
        write_reg(CFG_L3_INDEX, v_l3_idx);
        write_reg(CFG_L3_WAYS, v_l3_ways);
        if (phase % 3 == 0)
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7,
                      CFG_DATA_W'($urandom_range(0, 15)));
    endtask

    // bursts of items with random gaps, now and then a long unbroken run
    task automatic run_random_items(input int n_items);
        int sent, burst, gap;
        sent = 0;
        while (sent < n_items)
        begin
            burst = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < n_items; k++)
            begin
                send_addr(next_addr(), 1'b0, '0);
                sent++;
            end
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial
    begin : rsp_stall
        int mode, left, hold;
        mode = 0;
        left = 0;
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (hold = 1; hold < HOLD_CYCLES; hold++)
                    @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
                    2: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: rsp_ch.ready <= (left % 5 != 0);
                endcase
                left--;
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        lookup_result_t want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("item with nothing pending", '0, '0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.l2_hit !== want.l2_hit)
                    report_mismatch("l2_hit", 64'(rsp_ch.l2_hit), 64'(want.l2_hit));
                if (rsp_ch.l3_hit !== want.l3_hit)
                    report_mismatch("l3_hit", 64'(rsp_ch.l3_hit), 64'(want.l3_hit));
                if (rsp_ch.filled !== want.filled)
                    report_mismatch("filled", 64'(rsp_ch.filled), 64'(want.filled));
                if (rsp_ch.fill_way !== want.fill_way)
                    report_mismatch("fill_way", 64'(rsp_ch.fill_way), 64'(want.fill_way));
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no item moving on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("two_level_cache_tag_lookup_tb: done, errors");
        $finish;
    end

    // main sequence
    initial
    begin : stimulus
        mismatch_count = 0;
        results_seen   = 0;
        long_hold_req  = 1'b0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.miss_address <= '0;
        clear_tag_model();
        build_directed_rows();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // the block clears its stores before it takes the first item
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                drain_lookups();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
            end
            else
                send_addr(directed_rows[i].addr, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_lookups();

        for (int p = 0; p < PHASES; p++)
        begin
            configure_phase(p);
            if (p == 2)
                long_hold_req = 1'b1;
            run_random_items(ITEMS_PER_PHASE);
            drain_lookups();
        end

        if (mismatch_count == 0)
            $display("two_level_cache_tag_lookup_tb: done, clean");
        else
            $display("two_level_cache_tag_lookup_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
hdl/tlc_pkg.sv
hdl/tlc_if.sv
hdl/tlc_split.sv
hdl/tlc_tag_store.sv
hdl/two_level_cache_tag_lookup.sv
sim/two_level_cache_tag_lookup_tb.sv
